// File: hdl/srq_pkg.sv
// ----------------------------------------------------------------------------
// srq_pkg
// shared sizes, command codes, status codes and the per-cell command bundle
// ----------------------------------------------------------------------------
package srq_pkg;

    localparam int DEPTH         = 16;
    localparam int HANDLE_BITS   = 8;
    localparam int PRIORITY_BITS = 8;
    localparam int CNT_BITS      = $clog2(DEPTH + 1);

    // command kinds
    localparam logic [1:0] OP_SORTED = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_POP    = 2'd3;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_EMPTY     = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_QUEUED    = 3'd4;

    // broadcast to every cell of the row
    typedef struct packed {
        logic                     sorted;  // insert position follows priority
        logic                     do_ins;  // open a gap and write the new entry
        logic                     do_rm;   // close the gap at the marked entry
        logic [HANDLE_BITS-1:0]   handle;
        logic [PRIORITY_BITS-1:0] pri;
    } cell_cmd_t;

endpackage

// File: hdl/srq_cell.sv
// ----------------------------------------------------------------------------
// srq_cell
// one queue slot: holds an entry, compares it, shifts toward either neighbor
// ----------------------------------------------------------------------------
module srq_cell
    import srq_pkg::*;
(
    input  logic                     aclk,
    input  cell_cmd_t                cmd,
    input  logic                     valid,       // slot holds a live entry
    input  logic [HANDLE_BITS-1:0]   left_handle,
    input  logic [PRIORITY_BITS-1:0] left_pri,
    input  logic [HANDLE_BITS-1:0]   right_handle,
    input  logic [PRIORITY_BITS-1:0] right_pri,
    input  logic                     ins_in,      // insert point lies at a lower slot
    output logic                     ins_out,
    input  logic                     rm_in,       // removed entry lies at a lower slot
    output logic                     rm_out,
    output logic [HANDLE_BITS-1:0]   handle,
    output logic [PRIORITY_BITS-1:0] pri
);

    logic [HANDLE_BITS-1:0]   handle_reg, handle_next;
    logic [PRIORITY_BITS-1:0] pri_reg, pri_next;
    logic                     ins_here;
    logic                     match;

    always_comb begin
        ins_here    = cmd.sorted && valid && (pri_reg > cmd.pri);
        ins_out     = ins_in | ins_here | ~valid;
        match       = valid && (handle_reg == cmd.handle);
        rm_out      = rm_in | match;
        handle_next = handle_reg;
        pri_next    = pri_reg;
        if (cmd.do_ins) begin
            if (ins_in) begin
                handle_next = left_handle;
                pri_next    = left_pri;
            end else if (ins_out) begin
                handle_next = cmd.handle;
                pri_next    = cmd.pri;
            end
        end else if (cmd.do_rm && rm_out) begin
            handle_next = right_handle;
            pri_next    = right_pri;
        end
    end

    always_ff @(posedge aclk) begin
        handle_reg <= handle_next;
        pri_reg    <= pri_next;
    end

    assign handle = handle_reg;
    assign pri    = pri_reg;

endmodule

// File: hdl/stable_priority_ready_queue.sv
// ----------------------------------------------------------------------------
// stable_priority_ready_queue
// ordered ready queue built as a row of compare-and-shift slots
// ----------------------------------------------------------------------------
// s_ channel takes one command word: s_tuser carries the command kind
// (sorted insert, append, remove by handle, pop head), s_tdata the handle
// and the priority. m_ channel returns one result word per command: status
// in m_tuser, popped handle/priority and the entry count after the command
// in m_tdata.
// every slot compares its entry with the command in parallel; the insert
// point and the removed slot ripple along the row as marks held by every
// later slot. the result is registered and shows on m_ the cycle
// after the command is taken; a new command can be taken every cycle,
// limited only by the output register.
// when the receiver stalls, the result word holds and s_tready stays low
// until it is taken.
// reset empties the queue at once (entry count to zero); slot contents are
// not cleared, slots at or beyond the count never affect a result.
// failed commands (duplicate handle, full, empty, not found) leave the
// queue untouched and report a status code.
// ----------------------------------------------------------------------------
module stable_priority_ready_queue
    import srq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] handle, [15:8] priority_req
    input  logic [1:0]  s_tuser,   // [1:0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_handle, [15:8] out_priority,
                                   // [20:16] entry_count, [23:21] zero
    output logic [2:0]  m_tuser    // [2:0] status
);

    // entry count, the only control state of the store
    logic [CNT_BITS-1:0] occ_reg, occ_next;

    // registered result word
    logic        m_tvalid_reg;
    logic [23:0] m_tdata_reg, m_tdata_next;
    logic [2:0]  m_tuser_reg, m_tuser_next;

    logic                     accept;
    logic [1:0]               op;
    cell_cmd_t                cmd;
    logic [DEPTH-1:0]         cell_valid;
    logic [DEPTH:0]           ins_chain;
    logic [DEPTH:0]           rm_chain;
    logic [HANDLE_BITS-1:0]   cell_handle [DEPTH];
    logic [PRIORITY_BITS-1:0] cell_pri    [DEPTH];
    logic                     found;
    logic                     full;
    logic                     empty;
    logic [2:0]               status;
    logic [7:0]               out_handle;
    logic [7:0]               out_pri;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign op       = s_tuser;

    assign full  = (occ_reg == CNT_BITS'(DEPTH));
    assign empty = (occ_reg == '0);

    // pop marks slot 0 as the removed entry, other kinds start with no mark
    assign ins_chain[0] = 1'b0;
    assign rm_chain[0]  = (op == OP_POP);
    // any live slot matching the handle (meaningless for pop)
    assign found        = rm_chain[DEPTH];

    // decide the command and its status from the current contents
    always_comb begin
        cmd.sorted = (op == OP_SORTED);
        cmd.handle = HANDLE_BITS'(s_tdata[7:0]);
        cmd.pri    = PRIORITY_BITS'(s_tdata[15:8]);
        cmd.do_ins = 1'b0;
        cmd.do_rm  = 1'b0;
        status     = ST_OK;
        out_handle = '0;
        out_pri    = '0;
        case (op)
            OP_SORTED, OP_APPEND: begin
                // duplicate check wins over full check
                if (found) begin
                    status = ST_QUEUED;
                end else if (full) begin
                    status = ST_FULL;
                end else begin
                    cmd.do_ins = accept;
                end
            end
            OP_REMOVE: begin
                if (!found) begin
                    status = ST_NOT_FOUND;
                end else begin
                    cmd.do_rm = accept;
                end
            end
            OP_POP: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    cmd.do_rm  = accept;
                    out_handle = 8'(cell_handle[0]);
                    out_pri    = 8'(cell_pri[0]);
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    // row of slots, head at slot 0
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [HANDLE_BITS-1:0]   lh, rh;
        logic [PRIORITY_BITS-1:0] lp, rp;

        assign cell_valid[i] = (CNT_BITS'(i) < occ_reg);

        if (i == 0) begin : g_head
            assign lh = cmd.handle;
            assign lp = cmd.pri;
        end else begin : g_left
            assign lh = cell_handle[i-1];
            assign lp = cell_pri[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign rh = cell_handle[i];
            assign rp = cell_pri[i];
        end else begin : g_right
            assign rh = cell_handle[i+1];
            assign rp = cell_pri[i+1];
        end

        srq_cell u_cell (
            .aclk         (aclk),
            .cmd          (cmd),
            .valid        (cell_valid[i]),
            .left_handle  (lh),
            .left_pri     (lp),
            .right_handle (rh),
            .right_pri    (rp),
            .ins_in       (ins_chain[i]),
            .ins_out      (ins_chain[i+1]),
            .rm_in        (rm_chain[i]),
            .rm_out       (rm_chain[i+1]),
            .handle       (cell_handle[i]),
            .pri          (cell_pri[i])
        );
    end

    // count follows the shift direction
    always_comb begin
        occ_next = occ_reg;
        if (cmd.do_ins) begin
            occ_next = occ_reg + CNT_BITS'(1);
        end else if (cmd.do_rm) begin
            occ_next = occ_reg - CNT_BITS'(1);
        end
    end

    always_comb begin
        m_tdata_next  = {3'b000, 5'(occ_next), out_pri, out_handle};
        m_tuser_next  = status;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (accept) begin
                occ_reg      <= occ_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
        if (accept) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: hdl/srq_chk.sv
// ----------------------------------------------------------------------------
// srq_chk
// port-level checks for the ready queue, bound to the top level
// ----------------------------------------------------------------------------
module srq_chk
    import srq_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [2:0]  m_tuser
);

    // stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // every taken command yields a result on the next cycle
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("command gave no result");

    // a failed command carries no entry
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_OK) |-> (m_tdata[15:0] == 16'd0))
        else $error("failed command carries entry data");

    // empty and full reports agree with the count
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_EMPTY) |-> (m_tdata[20:16] == 5'd0))
        else $error("empty status with entries held");

    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_FULL) |-> (m_tdata[20:16] == 5'(DEPTH)))
        else $error("full status below capacity");

endmodule

bind stable_priority_ready_queue srq_chk u_srq_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
